// ===== rtl/core/rxfrd_pkg.sv =====
`default_nettype none

package rxfrd_pkg;

    localparam int DEPTH  = 256;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int HELD_W = (PTR_W + 1 > 8) ? PTR_W + 1 : 8;

    typedef logic [PTR_W-1:0] t_ptr;

    // item kinds
    localparam logic [2:0] K_RX    = 3'd0;
    localparam logic [2:0] K_READ  = 3'd1;
    localparam logic [2:0] K_ARM   = 3'd2;
    localparam logic [2:0] K_TICK  = 3'd3;
    localparam logic [2:0] K_CLEAR = 3'd4;

    // wait status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_R = 8'h52;

    localparam logic [31:0] MS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       ok_prog;
        logic [2:0] err_prog;
        logic       active;
        logic [1:0] status;
    } t_match;

    function automatic t_ptr advance(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

    function automatic logic [7:0] held8(input t_ptr wp, input t_ptr rp);
        logic [HELD_W-1:0] w;
        logic [HELD_W-1:0] r;
        logic [HELD_W-1:0] h;
        w = HELD_W'(wp);
        r = HELD_W'(rp);
        if (wp >= rp) begin
            h = w - r;
        end else begin
            h = w + HELD_W'(DEPTH) - r;
        end
        return h[7:0];
    endfunction

    // both matchers advance on one byte; an OK hit leaves the error matcher as is
    function automatic t_match scan_byte(input t_match s, input logic [7:0] ch);
        t_match m;
        logic   ok_hit;
        m = s;
        ok_hit = 1'b0;
        if (ch == CH_O) begin
            m.ok_prog = 1'b1;
        end else if (s.ok_prog && ch == CH_K) begin
            m.status = ST_OK;
            m.active = 1'b0;
            ok_hit   = 1'b1;
        end else begin
            m.ok_prog = 1'b0;
        end
        if (!ok_hit) begin
            if (ch == CH_E) begin
                m.err_prog = 3'd1;
            end else if (s.err_prog == 3'd1 && ch == CH_R) begin
                m.err_prog = 3'd2;
            end else if (s.err_prog == 3'd2 && ch == CH_R) begin
                m.err_prog = 3'd3;
            end else if (s.err_prog == 3'd3 && ch == CH_O) begin
                m.err_prog = 3'd4;
            end else if (s.err_prog == 3'd4 && ch == CH_R) begin
                m.status = ST_ERROR;
                m.active = 1'b0;
            end else begin
                m.err_prog = 3'd0;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rx_fifo_with_response_detector.sv =====
`default_nettype none
// Receive byte ring with OK / ERROR response detection.
// Input channel (i_valid / o_ready) carries one item: a received byte, a read,
// an arm with a timeout, a millisecond tick or a clear. Each item gives one
// result on the output channel (o_valid / i_ready), held in an output register.
// Byte, tick, clear and unused kinds load their result at acceptance and show
// it in the cycle after; a read passes the store's registered read and then the
// S_RESP state; an arm scans the stored bytes up to a match (at most DEPTH-1),
// one byte per cycle through the store's single read port, then passes S_RESP.
// An arm with a zero timeout loads a timeout result at acceptance, with no scan.
// One item is in work at a time: o_ready drops while a read or arm is in work,
// and while a result waits and i_ready is low; a new item is taken in the same
// cycle a waiting result is taken.
// Reset empties the ring, cancels any wait and clears the status; store
// contents are left as they are.
module rx_fifo_with_response_detector import rxfrd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic [31:0] i_timeout_ms,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [7:0]  o_read_byte,
    output      logic        o_read_valid,
    output      logic        o_byte_dropped,
    output      logic [1:0]  o_wait_status,
    output      logic        o_waiting,
    output      logic [7:0]  o_fill_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]  r_state,   n_state;
    t_ptr        r_wp,      n_wp;
    t_ptr        r_rp,      n_rp;
    t_ptr        r_scan,    n_scan;
    logic        r_pend,    n_pend;
    logic        r_rd_hit,  n_rd_hit;
    logic        r_okp,     n_okp;
    logic [2:0]  r_errp,    n_errp;
    logic        r_active,  n_active;
    logic [31:0] r_elapsed, n_elapsed;
    logic [31:0] r_limit,   n_limit;
    logic [1:0]  r_status,  n_status;

    logic        r_out_valid;
    logic [7:0]  r_out_rbyte;
    logic        r_out_rvalid;
    logic        r_out_drop;
    logic [1:0]  r_out_status;
    logic        r_out_wait;
    logic [7:0]  r_out_fill;

    logic        out_free;
    logic        accept;
    logic        out_load;
    logic [7:0]  n_rbyte;
    logic        n_rvalid;
    logic        n_drop;

    logic        ram_we;
    logic        ram_re;
    t_ptr        ram_raddr;
    logic [7:0]  ram_rdata;

    t_match      cur;
    t_match      m;
    t_ptr        nxt_wp;
    logic [31:0] el_inc;

    rxfrd_ram #(
        .DEPTH_P (DEPTH),
        .DATA_W  (8)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_byte_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign cur      = '{ok_prog: r_okp, err_prog: r_errp, active: r_active, status: r_status};
    assign nxt_wp   = advance(r_wp);
    assign el_inc   = (r_elapsed != MS_MAX) ? r_elapsed + 32'd1 : r_elapsed;

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_scan    = r_scan;
        n_pend    = r_pend;
        n_rd_hit  = r_rd_hit;
        n_okp     = r_okp;
        n_errp    = r_errp;
        n_active  = r_active;
        n_elapsed = r_elapsed;
        n_limit   = r_limit;
        n_status  = r_status;
        out_load  = 1'b0;
        n_rbyte   = 8'd0;
        n_rvalid  = 1'b0;
        n_drop    = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_rp;
        m         = cur;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        K_RX: begin
                            out_load = 1'b1;
                            if (nxt_wp != r_rp) begin
                                ram_we = 1'b1;
                                n_wp   = nxt_wp;
                                if (r_active) begin
                                    m        = scan_byte(cur, i_byte_in);
                                    n_okp    = m.ok_prog;
                                    n_errp   = m.err_prog;
                                    n_active = m.active;
                                    n_status = m.status;
                                end
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        K_READ: begin
                            n_state = S_RESP;
                            if (r_rp != r_wp) begin
                                ram_re   = 1'b1;
                                n_rp     = advance(r_rp);
                                n_rd_hit = 1'b1;
                            end else begin
                                n_rd_hit = 1'b0;
                            end
                        end
                        K_ARM: begin
                            n_okp     = 1'b0;
                            n_errp    = 3'd0;
                            n_elapsed = 32'd0;
                            n_limit   = i_timeout_ms;
                            n_rd_hit  = 1'b0;
                            if (i_timeout_ms == 32'd0) begin
                                n_active = 1'b0;
                                n_status = ST_TIMEOUT;
                                out_load = 1'b1;
                            end else begin
                                n_active = 1'b1;
                                n_status = ST_NONE;
                                n_scan   = r_rp;
                                n_pend   = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        K_TICK: begin
                            out_load = 1'b1;
                            if (r_active) begin
                                n_elapsed = el_inc;
                                if (el_inc >= r_limit) begin
                                    n_active = 1'b0;
                                    n_status = ST_TIMEOUT;
                                end
                            end
                        end
                        K_CLEAR: begin
                            out_load = 1'b1;
                            n_wp     = '0;
                            n_rp     = '0;
                            n_active = 1'b0;
                            n_okp    = 1'b0;
                            n_errp   = 3'd0;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // byte read last cycle is matched now, next read issued alongside
                if (r_pend) begin
                    m = scan_byte(cur, ram_rdata);
                end
                n_okp    = m.ok_prog;
                n_errp   = m.err_prog;
                n_active = m.active;
                n_status = m.status;
                if (m.active && (r_scan != r_wp)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_scan;
                    n_scan    = advance(r_scan);
                    n_pend    = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    n_rvalid = r_rd_hit;
                    n_rbyte  = r_rd_hit ? ram_rdata : 8'd0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_pend      <= 1'b0;
            r_rd_hit    <= 1'b0;
            r_okp       <= 1'b0;
            r_errp      <= 3'd0;
            r_active    <= 1'b0;
            r_elapsed   <= 32'd0;
            r_limit     <= 32'd0;
            r_status    <= ST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_pend    <= n_pend;
            r_rd_hit  <= n_rd_hit;
            r_okp     <= n_okp;
            r_errp    <= n_errp;
            r_active  <= n_active;
            r_elapsed <= n_elapsed;
            r_limit   <= n_limit;
            r_status  <= n_status;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (out_load) begin
            r_out_rbyte  <= n_rbyte;
            r_out_rvalid <= n_rvalid;
            r_out_drop   <= n_drop;
            r_out_status <= n_status;
            r_out_wait   <= n_active;
            r_out_fill   <= held8(n_wp, n_rp);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_byte    = r_out_rbyte;
    assign o_read_valid   = r_out_rvalid;
    assign o_byte_dropped = r_out_drop;
    assign o_wait_status  = r_out_status;
    assign o_waiting      = r_out_wait;
    assign o_fill_count   = r_out_fill;

endmodule

`default_nettype wire

// ===== rtl/core/rxfrd_ram.sv =====
`default_nettype none

module rxfrd_ram #(
    parameter int DEPTH_P = 256,
    parameter int DATA_W  = 8,
    localparam int ADDR_W = $clog2(DEPTH_P)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH_P];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/rxfrd_chk.sv =====
`default_nettype none

module rxfrd_chk import rxfrd_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [2:0]  i_kind,
    input wire logic [31:0] i_timeout_ms,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_read_byte,
    input wire logic        o_read_valid,
    input wire logic        o_byte_dropped,
    input wire logic [1:0]  o_wait_status,
    input wire logic        o_waiting,
    input wire logic [7:0]  o_fill_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_byte) && $stable(o_fill_count)
            && $stable(o_wait_status) && $stable(o_waiting))
        else $error("result changed while stalled");

    // an empty read reports zero data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_read_valid |-> o_read_byte == 8'd0)
        else $error("read byte nonzero without read valid");

    // a running wait has no final status
    a_wait_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_waiting |-> o_wait_status == ST_NONE)
        else $error("status set while waiting");

    // a dropped byte and a popped byte never share a result
    a_drop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_dropped |-> !o_read_valid)
        else $error("drop and read in one result");

    // a zero-timeout arm ends at once with timeout
    a_zero_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind == K_ARM && i_timeout_ms == 32'd0
            |=> o_valid && o_wait_status == ST_TIMEOUT && !o_waiting)
        else $error("zero timeout arm did not time out");

endmodule

bind rx_fifo_with_response_detector rxfrd_chk u_rxfrd_chk (.*);

`default_nettype wire
